/* sv/scol_pkg.sv */
// shared widths and constants for the segment/circle overlap length unit
// no dependencies
`timescale 1ns / 1ps

package scol_pkg;

	localparam int COORD_W_DEF = 32;
	localparam int RADIUS_W    = 31;
	localparam int RADIUS_SQ_W = 2 * RADIUS_W;
	localparam int OUT_W       = 32;

endpackage

/* sv/segment_circle_overlap_length_unit.sv */
// segment/circle overlap length unit, fully pipelined
// depends on scol_pkg
`timescale 1ns / 1ps
//
// Gives the length of the part of a segment that lies inside a circle.
// Channels: an input beat (start_x .. radius, signed Q16.16 coordinates, unsigned
// Q15.16 radius) is taken at a rising edge with start high and busy low. busy is
// never raised: a new beat may be taken in every cycle.
// Result: inside_length (unsigned Q16.16, saturating at all ones) is shown for
// exactly one cycle with done high.
// Throughput is one beat per cycle; the depth is set by three bit-serial chains
// laid out as stages: the segment length root (one bit a stage), the two projection
// divides (one quotient bit a stage, side by side) and the chord half-length root.
// A segment of zero length (the only Q16.16 squared length below 1e-10) gives 0.
// Reset empties the pipeline: no result follows a reset until a new beat.
// The receiver cannot stall: results are shown as they leave the last stage.
//
module segment_circle_overlap_length_unit
	import scol_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_W_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] centre_x,
	input  logic signed [COORD_WIDTH-1:0] centre_y,
	input  logic        [RADIUS_W-1:0]    radius,
	output logic                          done,
	output logic        [OUT_W-1:0]       inside_length
);

	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int SUMW = (2 * W + 3 > RADIUS_SQ_W + 1) ? 2 * W + 3 : RADIUS_SQ_W + 1;
	localparam int NW   = 2 * W + 1;
	localparam int AW   = 2 * W + 2;
	localparam int SW   = W + 1;
	localparam int QW   = W + 3;
	localparam int RW   = RADIUS_W;
	localparam int R2W  = RADIUS_SQ_W;
	localparam int XW   = ((QW > RW) ? QW : RW) + 2;

	localparam int K_MUL = 0;
	localparam int K_SUM = 1;
	localparam int K_SQ0 = 2;
	localparam int K_DVI = K_SQ0 + SW;
	localparam int K_DV0 = K_DVI + 1;
	localparam int K_MP  = K_DV0 + QW;
	localparam int K_HH  = K_MP + 1;
	localparam int K_H0  = K_HH + 1;
	localparam int K_CL  = K_H0 + RW;
	localparam int K_OUT = K_CL + 1;
	localparam int NST   = K_OUT + 1;

	typedef struct packed {
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic signed [DW-1:0] ex;
		logic signed [DW-1:0] ey;
		logic signed [DW-1:0] fx;
		logic signed [DW-1:0] fy;
		logic        [RW-1:0] r;
		logic signed [PW-1:0] pdxx;
		logic signed [PW-1:0] pdyy;
		logic signed [PW-1:0] pexx;
		logic signed [PW-1:0] peyy;
		logic signed [PW-1:0] pfxx;
		logic signed [PW-1:0] pfyy;
		logic signed [PW-1:0] pdxex;
		logic signed [PW-1:0] pdyey;
		logic signed [PW-1:0] pdxey;
		logic signed [PW-1:0] pdyex;
		logic        [R2W-1:0] r2;
		logic                  both;
		logic                  dneg;
		logic        [AW-1:0]  sq_rad;
		logic        [SW+1:0]  sq_rem;
		logic        [SW-1:0]  sq_root;
		logic        [NW-1:0]  dot_n;
		logic        [NW-1:0]  crs_n;
		logic        [SW-1:0]  len;
		logic        [SW:0]    dot_rem;
		logic        [SW:0]    crs_rem;
		logic        [QW-1:0]  dot_q;
		logic        [QW-1:0]  crs_q;
		logic                  hit;
		logic        [R2W-1:0] pp;
		logic        [R2W-1:0] h_rad;
		logic        [RW+1:0]  h_rem;
		logic        [RW-1:0]  h_root;
		logic signed [XW-1:0]  lo;
		logic signed [XW-1:0]  hi;
		logic        [OUT_W-1:0] res;
	} pl_t;

	function automatic pl_t len_root_step(input pl_t p);
		pl_t          o;
		logic [SW+1:0] rem_n;
		logic [SW+1:0] trial;
		o     = p;
		rem_n = {p.sq_rem[SW-1:0], p.sq_rad[AW-1:AW-2]};
		trial = {p.sq_root, 2'b01};
		o.sq_rad = {p.sq_rad[AW-3:0], 2'b00};
		if (rem_n >= trial) begin
			o.sq_rem  = rem_n - trial;
			o.sq_root = {p.sq_root[SW-2:0], 1'b1};
		end else begin
			o.sq_rem  = rem_n;
			o.sq_root = {p.sq_root[SW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic pl_t half_root_step(input pl_t p);
		pl_t          o;
		logic [RW+1:0] rem_n;
		logic [RW+1:0] trial;
		o     = p;
		rem_n = {p.h_rem[RW-1:0], p.h_rad[R2W-1:R2W-2]};
		trial = {p.h_root, 2'b01};
		o.h_rad = {p.h_rad[R2W-3:0], 2'b00};
		if (rem_n >= trial) begin
			o.h_rem  = rem_n - trial;
			o.h_root = {p.h_root[RW-2:0], 1'b1};
		end else begin
			o.h_rem  = rem_n;
			o.h_root = {p.h_root[RW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic pl_t div_step(input pl_t p);
		pl_t        o;
		logic [SW:0] rd;
		logic [SW:0] rc;
		o  = p;
		rd = {p.dot_rem[SW-1:0], p.dot_q[QW-1]};
		rc = {p.crs_rem[SW-1:0], p.crs_q[QW-1]};
		if (rd >= {1'b0, p.len}) begin
			o.dot_rem = rd - {1'b0, p.len};
			o.dot_q   = {p.dot_q[QW-2:0], 1'b1};
		end else begin
			o.dot_rem = rd;
			o.dot_q   = {p.dot_q[QW-2:0], 1'b0};
		end
		if (rc >= {1'b0, p.len}) begin
			o.crs_rem = rc - {1'b0, p.len};
			o.crs_q   = {p.crs_q[QW-2:0], 1'b1};
		end else begin
			o.crs_rem = rc;
			o.crs_q   = {p.crs_q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

	pl_t          st_s [0:NST];
	logic [NST:0] vld_s;
	pl_t          entry;

	assign busy = 1'b0;

	always_comb begin
		entry    = st_s[0];
		entry.dx = DW'(end_x) - DW'(start_x);
		entry.dy = DW'(end_y) - DW'(start_y);
		entry.ex = DW'(centre_x) - DW'(start_x);
		entry.ey = DW'(centre_y) - DW'(start_y);
		entry.fx = DW'(centre_x) - DW'(end_x);
		entry.fy = DW'(centre_y) - DW'(end_y);
		entry.r  = radius;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[NST-1:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_s[0] <= entry;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_stage
		pl_t nxt;

		if (k == K_MUL) begin : g_mul
			always_comb begin
				nxt       = st_s[k];
				nxt.pdxx  = st_s[k].dx * st_s[k].dx;
				nxt.pdyy  = st_s[k].dy * st_s[k].dy;
				nxt.pexx  = st_s[k].ex * st_s[k].ex;
				nxt.peyy  = st_s[k].ey * st_s[k].ey;
				nxt.pfxx  = st_s[k].fx * st_s[k].fx;
				nxt.pfyy  = st_s[k].fy * st_s[k].fy;
				nxt.pdxex = st_s[k].dx * st_s[k].ex;
				nxt.pdyey = st_s[k].dy * st_s[k].ey;
				nxt.pdxey = st_s[k].dx * st_s[k].ey;
				nxt.pdyex = st_s[k].dy * st_s[k].ex;
				nxt.r2    = R2W'(st_s[k].r) * R2W'(st_s[k].r);
			end
		end else if (k == K_SUM) begin : g_sum
			always_comb begin : sum_blk
				logic signed [SUMW-1:0] a_w;
				logic signed [SUMW-1:0] e2_w;
				logic signed [SUMW-1:0] f2_w;
				logic signed [SUMW-1:0] dot_w;
				logic signed [SUMW-1:0] crs_w;
				logic signed [SUMW-1:0] r2_w;
				nxt   = st_s[k];
				a_w   = SUMW'(st_s[k].pdxx) + SUMW'(st_s[k].pdyy);
				e2_w  = SUMW'(st_s[k].pexx) + SUMW'(st_s[k].peyy);
				f2_w  = SUMW'(st_s[k].pfxx) + SUMW'(st_s[k].pfyy);
				dot_w = SUMW'(st_s[k].pdxex) + SUMW'(st_s[k].pdyey);
				crs_w = SUMW'(st_s[k].pdxey) - SUMW'(st_s[k].pdyex);
				r2_w  = SUMW'($signed({1'b0, st_s[k].r2}));
				nxt.both    = (e2_w < r2_w) && (f2_w < r2_w);
				nxt.dneg    = dot_w[SUMW-1];
				nxt.dot_n   = NW'(dot_w[SUMW-1] ? -dot_w : dot_w);
				nxt.crs_n   = NW'(crs_w[SUMW-1] ? -crs_w : crs_w);
				nxt.sq_rad  = AW'(a_w);
				nxt.sq_rem  = '0;
				nxt.sq_root = '0;
			end
		end else if (k < K_DVI) begin : g_len_root
			always_comb begin
				nxt = len_root_step(st_s[k]);
			end
		end else if (k == K_DVI) begin : g_div_init
			always_comb begin
				nxt         = st_s[k];
				nxt.len     = st_s[k].sq_root;
				nxt.dot_rem = (SW + 1)'(st_s[k].dot_n >> QW);
				nxt.crs_rem = (SW + 1)'(st_s[k].crs_n >> QW);
				nxt.dot_q   = st_s[k].dot_n[QW-1:0];
				nxt.crs_q   = st_s[k].crs_n[QW-1:0];
			end
		end else if (k < K_MP) begin : g_div
			always_comb begin
				nxt = div_step(st_s[k]);
			end
		end else if (k == K_MP) begin : g_dist_sq
			always_comb begin : dist_blk
				logic [RW-1:0] pt;
				nxt     = st_s[k];
				pt      = RW'(st_s[k].crs_q);
				nxt.hit = XW'(st_s[k].crs_q) <= XW'(st_s[k].r);
				nxt.pp  = R2W'(pt) * R2W'(pt);
			end
		end else if (k == K_HH) begin : g_half_init
			always_comb begin
				nxt        = st_s[k];
				nxt.h_rad  = st_s[k].hit ? st_s[k].r2 - st_s[k].pp : '0;
				nxt.h_rem  = '0;
				nxt.h_root = '0;
			end
		end else if (k < K_CL) begin : g_half_root
			always_comb begin
				nxt = half_root_step(st_s[k]);
			end
		end else if (k == K_CL) begin : g_clamp
			always_comb begin : clamp_blk
				logic signed [XW-1:0] s_w;
				logic signed [XW-1:0] h_w;
				logic signed [XW-1:0] l_w;
				logic signed [XW-1:0] lo_w;
				logic signed [XW-1:0] hi_w;
				nxt  = st_s[k];
				s_w  = $signed(XW'(st_s[k].dot_q));
				if (st_s[k].dneg) begin
					s_w = -s_w;
				end
				h_w  = $signed(XW'(st_s[k].h_root));
				l_w  = $signed(XW'(st_s[k].len));
				lo_w = s_w - h_w;
				hi_w = s_w + h_w;
				if (lo_w < 0) begin
					lo_w = '0;
				end else if (lo_w > l_w) begin
					lo_w = l_w;
				end
				if (hi_w < 0) begin
					hi_w = '0;
				end else if (hi_w > l_w) begin
					hi_w = l_w;
				end
				nxt.lo = lo_w;
				nxt.hi = hi_w;
			end
		end else begin : g_out
			always_comb begin : out_blk
				logic [XW-1:0] full;
				nxt = st_s[k];
				if (st_s[k].both) begin
					full = XW'(st_s[k].len);
				end else if (st_s[k].len == '0 || !st_s[k].hit) begin
					full = '0;
				end else if (st_s[k].hi > st_s[k].lo) begin
					full = XW'(st_s[k].hi - st_s[k].lo);
				end else begin
					full = '0;
				end
				if (full > XW'({OUT_W{1'b1}})) begin
					nxt.res = {OUT_W{1'b1}};
				end else begin
					nxt.res = OUT_W'(full);
				end
			end
		end

		always_ff @(posedge clk) begin
			st_s[k+1] <= nxt;
		end
	end

	assign done          = vld_s[NST];
	assign inside_length = st_s[NST].res;

endmodule
